>>> src/session_hop_table_core_defines.svh
// ---------------------------------------------------------------------------
// Session hop table assertion macros
// Concurrent check helpers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef SESSION_HOP_TABLE_CORE_DEFINES_SVH
`define SESSION_HOP_TABLE_CORE_DEFINES_SVH

`ifndef SYNTH
`define SHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> src/sht_pkg.sv
// ---------------------------------------------------------------------------
// Session hop table package
// Shared widths, codes and controller-to-datapath command type.
// ---------------------------------------------------------------------------
package sht_pkg;

  localparam int unsigned DEFAULT_ENTRIES     = 8;
  localparam int unsigned DEFAULT_HOP_ID_BITS = 8;

  localparam int unsigned KEY_W    = 256;
  localparam int unsigned HOP_W    = 8;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned STATUS_W = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

>>> src/sht_ctrl.sv
// ---------------------------------------------------------------------------
// Session hop table controller
// Sequences capture/compare and commit, owns the stream handshakes.
// ---------------------------------------------------------------------------
`include "session_hop_table_core_defines.svh"

module sht_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sht_pkg::dp_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  assign cmd_o.capture = in_valid_i && in_ready_q;
  assign cmd_o.commit  = (state_q == S_EVAL) && (!out_valid_q || out_ready_i);
  assign in_ready_o    = in_ready_q;
  assign out_valid_o   = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= S_EVAL;
            in_ready_q <= 1'b0;
          end
        end
        S_EVAL: begin
          if (!out_valid_q || out_ready_i) begin
            in_ready_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  `SHT_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, cmd_o.capture, !in_ready_o,
                  "transfer accepted while an item is in flight")
  `SHT_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, cmd_o.commit,
                  !out_valid_o || out_ready_i, "pending result overwritten")
  `SHT_ASSERT_NXT(a_commit_shows, clk_i, rst_ni, cmd_o.commit, out_valid_o,
                  "committed result not presented")
  `SHT_ASSERT_IMP(a_no_mixed, clk_i, rst_ni, cmd_o.capture, !cmd_o.commit,
                  "capture and commit in the same cycle")

endmodule

>>> src/sht_dp.sv
// ---------------------------------------------------------------------------
// Session hop table datapath
// Entry storage, parallel key match, priority select and result register.
// ---------------------------------------------------------------------------
module sht_dp #(
  parameter int unsigned ENTRIES     = sht_pkg::DEFAULT_ENTRIES,
  parameter int unsigned HOP_ID_BITS = sht_pkg::DEFAULT_HOP_ID_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sht_pkg::dp_cmd_t             cmd_i,
  input  logic                         in_command_i,
  input  logic [sht_pkg::KEY_W-1:0]    in_key_i,
  input  logic [sht_pkg::HOP_W-1:0]    in_prev_i,
  input  logic [sht_pkg::HOP_W-1:0]    in_next_i,
  output logic [sht_pkg::STATUS_W-1:0] out_status_o,
  output logic [sht_pkg::HOP_W-1:0]    out_prev_o,
  output logic [sht_pkg::HOP_W-1:0]    out_next_o,
  output logic [sht_pkg::SLOT_W-1:0]   out_slot_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [ENTRIES-1:0]        valid_q;
  logic [sht_pkg::KEY_W-1:0] key_q  [ENTRIES];
  logic [HOP_ID_BITS-1:0]    prev_q [ENTRIES];
  logic [HOP_ID_BITS-1:0]    next_q [ENTRIES];

  logic                      lookup_q;
  logic [sht_pkg::KEY_W-1:0] key_in_q;
  logic [HOP_ID_BITS-1:0]    prev_in_q;
  logic [HOP_ID_BITS-1:0]    next_in_q;
  logic [ENTRIES-1:0]        hit_d, hit_q;
  logic [ENTRIES-1:0]        free_q;

  logic [IDX_W-1:0]          hit_idx, free_idx, sel_idx;
  logic                      hit_any, free_any, sel_any, wr_en;

  sht_pkg::status_e          status_d;
  logic [sht_pkg::HOP_W-1:0] prev_out_d, next_out_d;

  logic [sht_pkg::STATUS_W-1:0] status_q;
  logic [sht_pkg::HOP_W-1:0]    prev_out_q, next_out_q;
  logic [sht_pkg::SLOT_W-1:0]   slot_q;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_d[i] = valid_q[i] && (key_q[i] == in_key_i);
    end
  end

  // lowest index wins
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (free_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit_any  = |hit_q;
  assign free_any = |free_q;
  assign sel_idx  = lookup_q ? hit_idx : free_idx;
  assign sel_any  = lookup_q ? hit_any : free_any;
  assign wr_en    = cmd_i.commit && !lookup_q && free_any;

  always_comb begin
    prev_out_d = '0;
    next_out_d = '0;
    if (lookup_q) begin
      status_d = hit_any ? sht_pkg::ST_FOUND : sht_pkg::ST_NOT_FOUND;
      if (hit_any) begin
        prev_out_d = sht_pkg::HOP_W'(prev_q[hit_idx]);
        next_out_d = sht_pkg::HOP_W'(next_q[hit_idx]);
      end
    end else begin
      status_d = free_any ? sht_pkg::ST_INSERTED : sht_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lookup_q  <= (in_command_i == sht_pkg::CMD_LOOKUP);
      key_in_q  <= in_key_i;
      prev_in_q <= HOP_ID_BITS'(in_prev_i);
      next_in_q <= HOP_ID_BITS'(in_next_i);
      hit_q     <= hit_d;
      free_q    <= ~valid_q;
    end
    if (wr_en) begin
      key_q[free_idx]  <= key_in_q;
      prev_q[free_idx] <= prev_in_q;
      next_q[free_idx] <= next_in_q;
    end
    if (cmd_i.commit) begin
      status_q   <= status_d;
      prev_out_q <= prev_out_d;
      next_out_q <= next_out_d;
      slot_q     <= sel_any ? sht_pkg::SLOT_W'(sel_idx) : '0;
    end
  end

  assign out_status_o = status_q;
  assign out_prev_o   = prev_out_q;
  assign out_next_o   = next_out_q;
  assign out_slot_o   = slot_q;

endmodule

>>> src/session_hop_table_core.sv
// ---------------------------------------------------------------------------
// Session hop table core
// Per-node session table keyed by a 256-bit session id.
// ---------------------------------------------------------------------------
// Input stream: tuser carries the command (insert or lookup), tdata the four
// key words followed by the previous and next hop ids. An insert takes the
// lowest free entry or reports table full; a lookup returns the lowest valid
// entry whose full key matches, or not found.
// Output stream: tuser carries the status, tdata the hops and entry slot.
// Every item yields exactly one result.
// Each item's key is compared against all entries as it is accepted; at commit
// the entry is picked and, for an insert, written. The next item is accepted
// only after the previous one is committed, and the result is then presented from the output register.
// Reset clears all valid marks at once; the table is empty and ready in the
// first cycle after reset is released.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and compared, then waits until the output is taken.
// ---------------------------------------------------------------------------
module session_hop_table_core #(
  parameter int unsigned ENTRIES     = sht_pkg::DEFAULT_ENTRIES,
  parameter int unsigned HOP_ID_BITS = sht_pkg::DEFAULT_HOP_ID_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [271:0] s_axis_tdata,  // key_word0..3, prev_hop_in, next_hop_in
  input  logic         s_axis_tuser,  // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,  // prev_hop_out, next_hop_out, entry_slot, pad
  output logic [1:0]   m_axis_tuser   // status
);

  sht_pkg::dp_cmd_t             dp_cmd;
  logic [sht_pkg::STATUS_W-1:0] status;
  logic [sht_pkg::HOP_W-1:0]    prev_out;
  logic [sht_pkg::HOP_W-1:0]    next_out;
  logic [sht_pkg::SLOT_W-1:0]   slot_out;

  sht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (dp_cmd)
  );

  sht_dp #(
    .ENTRIES     (ENTRIES),
    .HOP_ID_BITS (HOP_ID_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .in_command_i (s_axis_tuser),
    .in_key_i     (s_axis_tdata[255:0]),
    .in_prev_i    (s_axis_tdata[263:256]),
    .in_next_i    (s_axis_tdata[271:264]),
    .out_status_o (status),
    .out_prev_o   (prev_out),
    .out_next_o   (next_out),
    .out_slot_o   (slot_out)
  );

  assign m_axis_tuser = status;
  assign m_axis_tdata = {5'd0, slot_out, next_out, prev_out};

endmodule
